FILE: rtl/flame_gas_alarm_latch_assert.svh
// Assertion macros for the flame and gas alarm latch.
`ifndef FLAME_GAS_ALARM_LATCH_ASSERT_SVH
`define FLAME_GAS_ALARM_LATCH_ASSERT_SVH

// check that a condition on one edge implies a consequence on the same edge
`define FGAL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("alarm latch check failed");

// check that a condition on one edge implies a consequence on the next edge
`define FGAL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("alarm latch sequence check failed");

`endif

FILE: rtl/fgal_pkg.sv
// Types and constants shared by the flame and gas alarm latch.
package fgal_pkg;

    localparam int SAMPLE_W = 12;
    localparam int TICKS_W  = 32;
    localparam int CFG_IDX_W = 3;

    typedef logic [SAMPLE_W-1:0]  sample_t;
    typedef logic [TICKS_W-1:0]   ticks_t;
    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_FLAME_TRIGGER = 3'd0;
    localparam cfg_index_t REG_FLAME_REARM   = 3'd1;
    localparam cfg_index_t REG_GAS_TRIGGER   = 3'd2;
    localparam cfg_index_t REG_GAS_REARM     = 3'd3;
    localparam cfg_index_t REG_SUSTAIN_TICKS = 3'd4;

    localparam sample_t FLAME_TRIGGER_RST = 12'd500;
    localparam sample_t FLAME_REARM_RST   = 12'd10;
    localparam sample_t GAS_TRIGGER_RST   = 12'd1200;
    localparam sample_t GAS_REARM_RST     = 12'd800;
    localparam ticks_t  SUSTAIN_TICKS_RST = 32'd42000000;

endpackage

FILE: rtl/flame_gas_alarm_latch.sv
// Flame and gas alarm latch: poll register, alarm state update and result register.
// An accepted request moves from the poll register to the result register.
// Throughput: one request per clock unless stalled; the latch state feeds back on itself.
// The request side stalls only while the poll register holds a request and the result
// register is full and stalled.
// Reset: all latches, blocks, tick count and valid flags clear; thresholds take defaults.
`include "flame_gas_alarm_latch_assert.svh"

module flame_gas_alarm_latch (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  fgal_pkg::cfg_index_t cfg_index,
    input  fgal_pkg::ticks_t     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  fgal_pkg::sample_t    flame_sample,
    input  fgal_pkg::sample_t    gas_sample,
    input  logic                 clear_pressed,
    input  fgal_pkg::ticks_t     elapsed_ticks,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 emergency_active,
    output logic                 gas_active,
    output logic                 emergency_raised,
    output logic                 gas_raised,
    output logic                 flame_cleared,
    output logic                 gas_cleared,
    output logic                 flame_counting
);

    import fgal_pkg::*;

    sample_t flame_trigger_reg;
    sample_t flame_rearm_reg;
    sample_t gas_trigger_reg;
    sample_t gas_rearm_reg;
    ticks_t  sustain_ticks_reg;

    logic    p_valid_reg;
    sample_t p_flame_reg;
    sample_t p_gas_reg;
    logic    p_pressed_reg;
    ticks_t  p_dt_reg;

    logic   em_latch_reg, em_latch_next;
    logic   em_block_reg, em_block_next;
    logic   gas_latch_reg, gas_latch_next;
    logic   gas_block_reg, gas_block_next;
    ticks_t high_ticks_reg, high_ticks_next;
    logic   baseline_reg, baseline_next;
    logic   armed_reg, armed_next;
    logic   saw_release_reg, saw_release_next;

    logic   out_valid_reg;
    logic   em_active_reg, gas_active_reg, em_raised_reg, gas_raised_reg;
    logic   f_clr_reg, g_clr_reg, counting_reg;

    logic   e_raised, g_raised, f_clr, g_clr, counting;
    logic [TICKS_W:0] tick_sum;

    logic   advance;
    logic   take;
    logic   in_accept;

    assign advance   = !out_valid_reg || !out_stall;
    assign take      = p_valid_reg && advance;
    assign in_stall  = p_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flame_trigger_reg <= FLAME_TRIGGER_RST;
            flame_rearm_reg   <= FLAME_REARM_RST;
            gas_trigger_reg   <= GAS_TRIGGER_RST;
            gas_rearm_reg     <= GAS_REARM_RST;
            sustain_ticks_reg <= SUSTAIN_TICKS_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FLAME_TRIGGER: flame_trigger_reg <= cfg_data[SAMPLE_W-1:0];
                REG_FLAME_REARM:   flame_rearm_reg   <= cfg_data[SAMPLE_W-1:0];
                REG_GAS_TRIGGER:   gas_trigger_reg   <= cfg_data[SAMPLE_W-1:0];
                REG_GAS_REARM:     gas_rearm_reg     <= cfg_data[SAMPLE_W-1:0];
                REG_SUSTAIN_TICKS: sustain_ticks_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // poll register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (!in_stall)
            p_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            p_flame_reg   <= flame_sample;
            p_gas_reg     <= gas_sample;
            p_pressed_reg <= clear_pressed;
            p_dt_reg      <= elapsed_ticks;
        end
    end

    // alarm state update
    always_comb
    begin
        em_latch_next    = em_latch_reg;
        em_block_next    = em_block_reg;
        gas_latch_next   = gas_latch_reg;
        gas_block_next   = gas_block_reg;
        high_ticks_next  = high_ticks_reg;
        baseline_next    = baseline_reg;
        armed_next       = armed_reg;
        saw_release_next = saw_release_reg;
        e_raised         = 1'b0;
        g_raised         = 1'b0;
        f_clr            = 1'b0;
        g_clr            = 1'b0;
        counting         = 1'b0;
        tick_sum         = {1'b0, high_ticks_reg} + {1'b0, p_dt_reg};

        if (em_latch_reg || gas_latch_reg)
        begin
            if (!p_pressed_reg)
            begin
                saw_release_next = 1'b1;
                armed_next       = 1'b1;
            end
            else if (saw_release_reg && armed_reg)
            begin
                armed_next     = 1'b0;
                f_clr          = em_latch_reg;
                g_clr          = gas_latch_reg;
                em_latch_next  = 1'b0;
                em_block_next  = 1'b1;
                gas_latch_next = 1'b0;
                gas_block_next = 1'b1;
            end
        end

        if (p_flame_reg < flame_rearm_reg)
            em_block_next = 1'b0;
        if (!baseline_reg)
            high_ticks_next = '0;
        else
        begin
            counting = (p_flame_reg >= flame_trigger_reg) && !em_latch_next
                       && !em_block_next && !gas_latch_next;
            if (counting)
            begin
                if (tick_sum >= {1'b0, sustain_ticks_reg})
                begin
                    em_latch_next   = 1'b1;
                    e_raised        = 1'b1;
                    high_ticks_next = '0;
                end
                else
                    high_ticks_next = tick_sum[TICKS_W-1:0];
            end
            else
                high_ticks_next = '0;
        end

        if (p_gas_reg < gas_rearm_reg)
            gas_block_next = 1'b0;
        if ((p_gas_reg >= gas_trigger_reg) && !gas_latch_next && !gas_block_next
            && !em_latch_next)
        begin
            gas_latch_next = 1'b1;
            g_raised       = 1'b1;
        end

        if (p_flame_reg < flame_trigger_reg)
            baseline_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_latch_reg    <= 1'b0;
            em_block_reg    <= 1'b0;
            gas_latch_reg   <= 1'b0;
            gas_block_reg   <= 1'b0;
            high_ticks_reg  <= '0;
            baseline_reg    <= 1'b0;
            armed_reg       <= 1'b0;
            saw_release_reg <= 1'b0;
        end
        else if (take)
        begin
            em_latch_reg    <= em_latch_next;
            em_block_reg    <= em_block_next;
            gas_latch_reg   <= gas_latch_next;
            gas_block_reg   <= gas_block_next;
            high_ticks_reg  <= high_ticks_next;
            baseline_reg    <= baseline_next;
            armed_reg       <= armed_next;
            saw_release_reg <= saw_release_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= p_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            em_active_reg  <= em_latch_next;
            gas_active_reg <= gas_latch_next;
            em_raised_reg  <= e_raised;
            gas_raised_reg <= g_raised;
            f_clr_reg      <= f_clr;
            g_clr_reg      <= g_clr;
            counting_reg   <= counting;
        end
    end

    assign out_valid        = out_valid_reg;
    assign emergency_active = em_active_reg;
    assign gas_active       = gas_active_reg;
    assign emergency_raised = em_raised_reg;
    assign gas_raised       = gas_raised_reg;
    assign flame_cleared    = f_clr_reg;
    assign gas_cleared      = g_clr_reg;
    assign flame_counting   = counting_reg;

    `FGAL_ASSERT_IMP(a_raise_sets_latch, out_valid && emergency_raised, emergency_active && flame_counting)
    `FGAL_ASSERT_IMP(a_gas_yields_to_flame, out_valid && gas_raised, !emergency_active)
    `FGAL_ASSERT_IMP(a_clear_drops_gas, out_valid && gas_cleared && !gas_raised, !gas_active)
    `FGAL_ASSERT_NEXT(a_take_fills_result, take, out_valid_reg)

endmodule
